// File: src/sit_pkg.sv
// ----------------------------------------------------------------------------
// sit_pkg
// Shared types for the segment intersection test: the per-stage load
// strobes that the pipeline control hands to the datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package sit_pkg;

    // Load strobe for each register stage of the datapath
    typedef struct packed {
        logic s1;   // differences and extent check
        logic s2;   // partial products
        logic s3;   // cross products
        logic s4;   // result word
    } sit_load_t;

endpackage

`default_nettype wire

// File: src/sit_datapath.sv
// ----------------------------------------------------------------------------
// sit_datapath
// Four register stages of the intersection test: coordinate differences and
// extent check, six products, three cross products, sign and magnitude test.
// ----------------------------------------------------------------------------
`default_nettype none

module sit_datapath #(
    parameter int COORD_BITS = 16
) (
    input  wire logic                      clk,
    input  wire sit_pkg::sit_load_t        load,
    input  wire logic [8*COORD_BITS-1:0]   coords,   // eight packed coordinates
    output logic                           crosses
);

    localparam int D = COORD_BITS + 1;   // difference width
    localparam int P = 2 * D;            // product width
    localparam int X = P + 1;            // cross product width

    // Coordinates as signed values
    logic signed [COORD_BITS-1:0] vx1, vz1, vx2, vz2, wx1, wz1, wx2, wz2;

    assign vx1 = $signed(coords[0*COORD_BITS +: COORD_BITS]);
    assign vz1 = $signed(coords[1*COORD_BITS +: COORD_BITS]);
    assign vx2 = $signed(coords[2*COORD_BITS +: COORD_BITS]);
    assign vz2 = $signed(coords[3*COORD_BITS +: COORD_BITS]);
    assign wx1 = $signed(coords[4*COORD_BITS +: COORD_BITS]);
    assign wz1 = $signed(coords[5*COORD_BITS +: COORD_BITS]);
    assign wx2 = $signed(coords[6*COORD_BITS +: COORD_BITS]);
    assign wz2 = $signed(coords[7*COORD_BITS +: COORD_BITS]);

    // True when W lies wholly beyond one end of V on this axis
    function automatic logic outside(
        input logic signed [COORD_BITS-1:0] v1,
        input logic signed [COORD_BITS-1:0] v2,
        input logic signed [COORD_BITS-1:0] w1,
        input logic signed [COORD_BITS-1:0] w2
    );
        logic res;
        if (v1 < v2)
            res = (w1 < v1 && w2 < v1) || (w1 > v2 && w2 > v2);
        else
            res = (w1 > v1 && w2 > v1) || (w1 < v2 && w2 < v2);
        return res;
    endfunction

    // Numerator shares the denominator's sign and does not exceed its size
    function automatic logic ratio_ok(
        input logic signed [X-1:0] num,
        input logic signed [X-1:0] den
    );
        logic res;
        if (num[X-1] != den[X-1])
            res = 1'b0;
        else if (den[X-1])
            res = (num >= den);
        else
            res = (num <= den);
        return res;
    endfunction

    // Stage 1: differences and extent rejection
    logic signed [D-1:0] ax_reg, az_reg, bx_reg, bz_reg, dx_reg, dz_reg;
    logic                rej1_reg;

    always_ff @(posedge clk)
    begin
        if (load.s1)
        begin
            ax_reg   <= D'(vx2) - D'(vx1);
            az_reg   <= D'(vz2) - D'(vz1);
            bx_reg   <= D'(wx1) - D'(vx1);
            bz_reg   <= D'(wz1) - D'(vz1);
            dx_reg   <= D'(wx2) - D'(wx1);
            dz_reg   <= D'(wz2) - D'(wz1);
            rej1_reg <= outside(vx1, vx2, wx1, wx2) || outside(vz1, vz2, wz1, wz2);
        end
    end

    // Stage 2: six products at full width
    logic signed [P-1:0] dxaz_reg, dzax_reg, dxbz_reg, dzbx_reg, axbz_reg, azbx_reg;
    logic                rej2_reg;

    always_ff @(posedge clk)
    begin
        if (load.s2)
        begin
            dxaz_reg <= P'(dx_reg) * P'(az_reg);
            dzax_reg <= P'(dz_reg) * P'(ax_reg);
            dxbz_reg <= P'(dx_reg) * P'(bz_reg);
            dzbx_reg <= P'(dz_reg) * P'(bx_reg);
            axbz_reg <= P'(ax_reg) * P'(bz_reg);
            azbx_reg <= P'(az_reg) * P'(bx_reg);
            rej2_reg <= rej1_reg;
        end
    end

    // Stage 3: denominator and the two numerators
    logic signed [X-1:0] den_reg, nb_reg, na_reg;
    logic                rej3_reg;

    always_ff @(posedge clk)
    begin
        if (load.s3)
        begin
            den_reg  <= X'(dxaz_reg) - X'(dzax_reg);
            nb_reg   <= X'(dxbz_reg) - X'(dzbx_reg);
            na_reg   <= X'(axbz_reg) - X'(azbx_reg);
            rej3_reg <= rej2_reg;
        end
    end

    // Stage 4: sign and magnitude test into the result word
    logic crosses_reg;

    always_ff @(posedge clk)
    begin
        if (load.s4)
            crosses_reg <= !rej3_reg && ratio_ok(nb_reg, den_reg)
                                     && ratio_ok(na_reg, den_reg);
    end

    assign crosses = crosses_reg;

endmodule

`default_nettype wire

// File: src/segment_intersection_test_unit.sv
// ----------------------------------------------------------------------------
// segment_intersection_test_unit
// Tests two 2D segments V and W for intersection, one pair per clock while the receiver takes results.
//
// Input stream: one word carries eight signed coordinates, COORD_BITS each,
// lowest bits first: V start x, V start z, V end x, V end z, W start x,
// W start z, W end x, W end z. Output stream: one word per input word,
// bit 0 is the crosses flag, upper bits are zero.
// The four register stages (differences, products, cross products, sign test)
// each take one word per cycle unless the receiver stalls, so throughput is
// one pair per clock while m_axis_tready stays high.
// Each stage carries a valid bit and loads when it is empty or its successor
// loads; a stalled receiver holds the result word and the words behind it,
// while empty stages still fill, so s_axis_tready drops only when all four
// stages are full and the output is not taken.
// Reset clears all valid bits; the datapath registers are not reset.
// ----------------------------------------------------------------------------
`default_nettype none

module segment_intersection_test_unit #(
    parameter int COORD_BITS = 16
) (
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    // coordinates: V start x, V start z, V end x, V end z,
    //              W start x, W start z, W end x, W end z
    input  wire logic [((8*COORD_BITS+7)/8)*8-1:0] s_axis_tdata,
    input  wire logic                    s_axis_tvalid,
    output logic                         s_axis_tready,
    // bit 0: crosses; bits 7:1 zero
    output logic [7:0]                   m_axis_tdata,
    output logic                         m_axis_tvalid,
    input  wire logic                    m_axis_tready
);

    sit_pkg::sit_load_t load;
    logic [3:0]         valid_reg;
    logic [3:0]         valid_next;
    logic               crosses;

    // Load each stage when empty or when its successor moves on
    always_comb
    begin
        load.s4 = !valid_reg[3] || m_axis_tready;
        load.s3 = !valid_reg[2] || load.s4;
        load.s2 = !valid_reg[1] || load.s3;
        load.s1 = !valid_reg[0] || load.s2;
    end

    // Advance valid bits alongside the data
    always_comb
    begin
        valid_next[0] = load.s1 ? s_axis_tvalid : valid_reg[0];
        valid_next[1] = load.s2 ? valid_reg[0]  : valid_reg[1];
        valid_next[2] = load.s3 ? valid_reg[1]  : valid_reg[2];
        valid_next[3] = load.s4 ? valid_reg[2]  : valid_reg[3];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= '0;
        else
            valid_reg <= valid_next;
    end

    sit_datapath #(
        .COORD_BITS (COORD_BITS)
    ) u_datapath (
        .clk     (clk),
        .load    (load),
        .coords  (s_axis_tdata[8*COORD_BITS-1:0]),
        .crosses (crosses)
    );

    assign s_axis_tready = load.s1;
    assign m_axis_tvalid = valid_reg[3];
    assign m_axis_tdata  = {7'b0, crosses};

    // An accepted word always lands in the first stage
    assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> valid_reg[0])
        else $error("accepted word not captured in stage 1");

    // A stalled output with a waiting word in stage 3 must keep that word
    assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg[3] && !m_axis_tready && valid_reg[2] |=> valid_reg[2])
        else $error("word dropped from stage 3 under stall");

    // Back-pressure reaches the input only when every stage is full
    assert property (@(posedge clk) disable iff (!rst_n)
        !s_axis_tready |-> (valid_reg == 4'hF) && !m_axis_tready)
        else $error("input stalled with room in the pipeline");

    // A word in stage 3 reaches the output once the output is free
    assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg[2] && (!valid_reg[3] || m_axis_tready) |=> m_axis_tvalid)
        else $error("result did not reach the output register");

endmodule

`default_nettype wire

// File: tb/segment_intersection_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// segment_intersection_checker
// Watches both stream channels of the segment intersection unit. It works
// out the crosses flag of every accepted pair, queues it, and compares each
// result word taken from the block with the oldest queued word.
// ----------------------------------------------------------------------------

module segment_intersection_checker #(
    parameter int COORD_BITS = 16,
    parameter int PAIR_W     = ((8*COORD_BITS+7)/8)*8
) (
    input  logic              clk,
    input  logic              rst_n,
    // coordinates: V start x, V start z, V end x, V end z,
    //              W start x, W start z, W end x, W end z
    input  logic [PAIR_W-1:0] pair_tdata,
    input  logic              pair_tvalid,
    input  logic              pair_tready,
    // bit 0: crosses; bits 7:1 zero
    input  logic [7:0]        flag_tdata,
    input  logic              flag_tvalid,
    input  logic              flag_tready,
    output int                mismatch_count,
    output int                awaiting
);

    logic [7:0] expected_flags[$];
    logic [7:0] oldest_flag;

    // Sign-extend one coordinate of the pair word
    function automatic longint coord_of(input logic [PAIR_W-1:0] w, input int idx);
        logic signed [COORD_BITS-1:0] c;
        c = w[idx*COORD_BITS +: COORD_BITS];
        return longint'(c);
    endfunction

    // W lies wholly beyond one end of V on this axis; equal V ends count as
    // descending
    function automatic bit beyond_extent(input longint v1, input longint v2,
                                         input longint w1, input longint w2);
        if (v1 < v2)
            return (w1 < v1 && w2 < v1) || (w1 > v2 && w2 > v2);
        return (w1 > v1 && w2 > v1) || (w1 < v2 && w2 < v2);
    endfunction

    // Numerator shares the denominator's sign (zero non-negative) and fits
    function automatic bit ratio_fits(input longint num, input longint den);
        longint num_mag;
        longint den_mag;
        num_mag = (num < 0) ? -num : num;
        den_mag = (den < 0) ? -den : den;
        if ((num < 0) != (den < 0))
            return 1'b0;
        return num_mag <= den_mag;
    endfunction

    // Expected result word for one segment pair
    function automatic logic [7:0] crosses_word(input logic [PAIR_W-1:0] w);
        longint vx1, vz1, vx2, vz2, wx1, wz1, wx2, wz2;
        longint ax, az, bx, bz, dx, dz;
        longint den, num_w, num_v;
        bit     hit;
        vx1 = coord_of(w, 0);
        vz1 = coord_of(w, 1);
        vx2 = coord_of(w, 2);
        vz2 = coord_of(w, 3);
        wx1 = coord_of(w, 4);
        wz1 = coord_of(w, 5);
        wx2 = coord_of(w, 6);
        wz2 = coord_of(w, 7);
        ax = vx2 - vx1;
        az = vz2 - vz1;
        bx = wx1 - vx1;
        bz = wz1 - vz1;
        dx = wx2 - wx1;
        dz = wz2 - wz1;
        den   = dx * az - dz * ax;
        num_w = dx * bz - dz * bx;
        num_v = ax * bz - az * bx;
        hit = !beyond_extent(vx1, vx2, wx1, wx2) && !beyond_extent(vz1, vz2, wz1, wz2)
              && ratio_fits(num_w, den) && ratio_fits(num_v, den);
        return {7'b0, hit};
    endfunction

    task automatic report_mismatch(input string what);
        if (mismatch_count < 100)
            $display("[%0t] mismatch: %s", $time, what);
        mismatch_count++;
    endtask

    // Check taken result words, then queue the flag of an accepted pair
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            expected_flags.delete();
            awaiting = 0;
        end
        else
        begin
            if (flag_tvalid && flag_tready)
            begin
                if (expected_flags.size() == 0)
                    report_mismatch($sformatf("result word %02h with nothing expected",
                                              flag_tdata));
                else
                begin
                    oldest_flag = expected_flags.pop_front();
                    if (flag_tdata[0] !== oldest_flag[0])
                        report_mismatch($sformatf("crosses %b, expected %b",
                                                  flag_tdata[0], oldest_flag[0]));
                    if (flag_tdata[7:1] !== oldest_flag[7:1])
                        report_mismatch($sformatf("padding bits %b, expected zero",
                                                  flag_tdata[7:1]));
                end
            end
            if (pair_tvalid && pair_tready)
                expected_flags.push_back(crosses_word(pair_tdata));
            awaiting = expected_flags.size();
        end
    end

endmodule

// File: tb/tb_segment_intersection_test_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_segment_intersection_test_unit
// Drives segment pairs into the intersection unit: a directed set of corner
// cases, then random pairs shaped to cross, touch or lie collinear, under
// several sender and receiver idling mixes and one long receiver hold-off.
// The checker beside the block does the prediction and comparison.
// ----------------------------------------------------------------------------

module tb_segment_intersection_test_unit;

    localparam int COORD_BITS   = 16;
    localparam int PAIR_W       = ((8*COORD_BITS+7)/8)*8;
    localparam int PHASE_PAIRS  = 170;
    localparam int HOLD_PAIRS   = 80;
    localparam int HOLD_CYCLES  = 300;
    localparam int DRAIN_CYCLES = 20;
    localparam int CYCLE_LIMIT  = 200000;

    logic              clk;
    logic              rst_n;
    logic [PAIR_W-1:0] s_axis_tdata;
    logic              s_axis_tvalid;
    wire logic         s_axis_tready;
    wire logic [7:0]   m_axis_tdata;
    wire logic         m_axis_tvalid;
    logic              m_axis_tready;

    int mismatch_count;
    int awaiting;
    int sender_idle_pct;
    int stall_pct;
    bit hold_off;
    int cycle_count;

    segment_intersection_test_unit #(
        .COORD_BITS(COORD_BITS)
    ) i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready)
    );

    segment_intersection_checker #(
        .COORD_BITS(COORD_BITS)
    ) i_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .pair_tdata    (s_axis_tdata),
        .pair_tvalid   (s_axis_tvalid),
        .pair_tready   (s_axis_tready),
        .flag_tdata    (m_axis_tdata),
        .flag_tvalid   (m_axis_tvalid),
        .flag_tready   (m_axis_tready),
        .mismatch_count(mismatch_count),
        .awaiting      (awaiting)
    );

    // 10 ns clock
    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // Abandon the run if it hangs
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("segment_intersection_test_unit verification failed");
            $finish;
        end
    end

    // Receiver: stall at random, or hold off completely while asked to
    initial
    begin
        m_axis_tready = 1'b0;
        forever
        begin
            @(negedge clk);
            m_axis_tready <= hold_off ? 1'b0 : ($urandom_range(99) >= stall_pct);
        end
    end

    function automatic int rnd(input int lo, input int hi);
        return lo + int'($urandom_range(hi - lo));
    endfunction

    // Pack V start, V end, W start, W end into one pair word, V start x lowest
    function automatic logic [PAIR_W-1:0] pack_pair(
        input int vsx, input int vsz, input int vex, input int vez,
        input int wsx, input int wsz, input int wex, input int wez);
        logic [COORD_BITS-1:0] c[8];
        logic [PAIR_W-1:0]     w;
        c[0] = vsx[COORD_BITS-1:0];
        c[1] = vsz[COORD_BITS-1:0];
        c[2] = vex[COORD_BITS-1:0];
        c[3] = vez[COORD_BITS-1:0];
        c[4] = wsx[COORD_BITS-1:0];
        c[5] = wsz[COORD_BITS-1:0];
        c[6] = wex[COORD_BITS-1:0];
        c[7] = wez[COORD_BITS-1:0];
        w = '0;
        for (int i = 0; i < 8; i++)
            w[i*COORD_BITS +: COORD_BITS] = c[i];
        return w;
    endfunction

    // Random pair: mostly shaped to cross, touch or lie collinear
    function automatic logic [PAIR_W-1:0] random_pair();
        int cx, cz, ux, uz, px, pz;
        int t[4];
        int ext[5];
        ext = '{-32768, -1, 0, 1, 32767};
        cx = rnd(-20000, 20000);
        cz = rnd(-20000, 20000);
        case ($urandom_range(9))
            0, 1:
                return {$urandom, $urandom, $urandom, $urandom};
            2, 3:
                // tight cluster of points
                return pack_pair(cx + rnd(-8, 8), cz + rnd(-8, 8), cx + rnd(-8, 8),
                                 cz + rnd(-8, 8), cx + rnd(-8, 8), cz + rnd(-8, 8),
                                 cx + rnd(-8, 8), cz + rnd(-8, 8));
            4, 5:
            begin
                // both segments pass through one point
                ux = rnd(-10000, 10000);
                uz = rnd(-10000, 10000);
                px = rnd(-10000, 10000);
                pz = rnd(-10000, 10000);
                return pack_pair(cx - ux, cz - uz, cx + rnd(0, 2) * ux / 2,
                                 cz + rnd(0, 2) * uz / 2, cx - px, cz - pz, cx + px, cz + pz);
            end
            6, 7:
            begin
                // four points on one line
                ux = rnd(-50, 50);
                uz = rnd(-50, 50);
                for (int i = 0; i < 4; i++)
                    t[i] = rnd(-5, 5);
                return pack_pair(cx + t[0] * ux, cz + t[0] * uz, cx + t[1] * ux,
                                 cz + t[1] * uz, cx + t[2] * ux, cz + t[2] * uz,
                                 cx + t[3] * ux, cz + t[3] * uz);
            end
            8:
                return pack_pair(ext[$urandom_range(4)], ext[$urandom_range(4)],
                                 ext[$urandom_range(4)], ext[$urandom_range(4)],
                                 ext[$urandom_range(4)], ext[$urandom_range(4)],
                                 ext[$urandom_range(4)], ext[$urandom_range(4)]);
            default:
            begin
                // W starts on the end of V
                ux = cx + rnd(-1000, 1000);
                uz = cz + rnd(-1000, 1000);
                return pack_pair(cx, cz, ux, uz, ux, uz,
                                 ux + rnd(-1000, 1000), uz + rnd(-1000, 1000));
            end
        endcase
    endfunction

    // Offer one pair word after a random idle gap and hold it until taken
    task automatic send_pair(input logic [PAIR_W-1:0] w);
        while ($urandom_range(99) < sender_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_axis_tdata  <= w;
        s_axis_tvalid <= 1'b1;
        do
            @(posedge clk);
        while (!s_axis_tready);
        @(negedge clk);
    endtask

    task automatic send_random(input int count);
        for (int i = 0; i < count; i++)
            send_pair(random_pair());
    endtask

    initial
    begin
        rst_n           = 1'b0;
        s_axis_tvalid   = 1'b0;
        s_axis_tdata    = '0;
        sender_idle_pct = 0;
        stall_pct       = 0;
        hold_off        = 1'b0;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed corner cases
        send_pair(pack_pair(-32768, -32768, -32768, -32768, -32768, -32768, -32768, -32768));
        send_pair(pack_pair(32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767));
        send_pair(pack_pair(-32768, -32768, 32767, 32767, -32768, 32767, 32767, -32768));
        send_pair(pack_pair(-32768, 32767, 32767, -32768, -32768, -32768, 32767, 32767));
        send_pair(pack_pair(0, 0, 10, 10, 0, 10, 10, 0));
        send_pair(pack_pair(0, 0, 10, 10, 10, 0, 0, 10));
        send_pair(pack_pair(-1, -1, 1, 1, -1, 1, 1, -1));
        // parallel, then collinear overlapping and collinear apart
        send_pair(pack_pair(0, 0, 10, 0, 0, 5, 10, 5));
        send_pair(pack_pair(0, 0, 10, 0, 5, 0, 15, 0));
        send_pair(pack_pair(0, 0, 10, 0, 20, 0, 30, 0));
        // touching at an end, and a T junction
        send_pair(pack_pair(0, 0, 10, 0, 10, -5, 10, 5));
        send_pair(pack_pair(0, 0, 10, 0, 5, 0, 5, 5));
        // equal V ends on one axis, and V running backwards
        send_pair(pack_pair(3, -10, 3, 10, -5, 0, 5, 0));
        send_pair(pack_pair(-5, 4, 5, 4, 0, -32768, 0, 32767));
        send_pair(pack_pair(10, 10, 0, 0, 10, 0, 0, 10));
        // W wholly beyond V in X, then in Z
        send_pair(pack_pair(0, 0, 10, 10, 20, 0, 30, 10));
        send_pair(pack_pair(0, 0, 10, 10, 0, 20, 10, 30));
        // zero-length segments, coincident and apart
        send_pair(pack_pair(7, 7, 7, 7, 7, 7, 7, 7));
        send_pair(pack_pair(1, 1, 1, 1, 2, 2, 2, 2));
        // W stops short of V
        send_pair(pack_pair(0, 0, 10, 10, 0, 10, 4, 6));

        // Random pairs under each idling mix
        for (int phase = 0; phase < 4; phase++)
        begin
            case (phase)
                0: begin sender_idle_pct = 0;  stall_pct = 0;  end
                1: begin sender_idle_pct = 64; stall_pct = 0;  end
                2: begin sender_idle_pct = 0;  stall_pct = 64; end
                default: begin sender_idle_pct = 38; stall_pct = 38; end
            endcase
            send_random(PHASE_PAIRS);
        end

        // Hold the receiver off while the sender keeps offering
        sender_idle_pct = 0;
        stall_pct       = 0;
        fork
            begin
                hold_off = 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_off = 1'b0;
            end
        join_none
        send_random(HOLD_PAIRS);

        // Drain and settle
        s_axis_tvalid <= 1'b0;
        while (awaiting != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);

        if (mismatch_count == 0)
            $display("segment_intersection_test_unit verification clean");
        else
            $display("segment_intersection_test_unit verification failed");
        $finish;
    end

endmodule
